// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL of the macroblock color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ----- rtl/core/mbycc_pkg.sv -----
// Shared constants, types and helpers of the macroblock color converter.
package mbycc_pkg;

    // Macroblock geometry (4:2:0, 16x16 luma, 8x8 chroma)
    localparam int MB_SIDE       = 16;
    localparam int CHROMA_SIDE   = MB_SIDE / 2;
    localparam int CHROMA_DEPTH  = CHROMA_SIDE * CHROMA_SIDE;
    localparam int CHROMA_AW     = $clog2(CHROMA_DEPTH);
    localparam int COORD_W       = $clog2(MB_SIDE);
    localparam int LUMA_START    = 2 * CHROMA_DEPTH;
    localparam int TOTAL_SAMPLES = LUMA_START + MB_SIDE * MB_SIDE;
    localparam int POS_W         = $clog2(TOTAL_SAMPLES);

    localparam logic [POS_W-1:0] POS_CB_START = POS_W'(CHROMA_DEPTH);
    localparam logic [POS_W-1:0] POS_LUMA     = POS_W'(LUMA_START);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(TOTAL_SAMPLES - 1);

    // Sample and arithmetic widths
    localparam int SAMPLE_W = 16;
    localparam int LUM_W    = SAMPLE_W + 1;        // sample + 128
    localparam int PROD_W   = 2 * SAMPLE_W;        // 16 x 16 signed product
    localparam int SUM_W    = 34;                  // headroom for three terms
    localparam int Q_SHIFT  = 14;

    // Q14 conversion coefficients
    localparam logic signed [SAMPLE_W-1:0] COEF_R_CR = 16'sd22971;
    localparam logic signed [SAMPLE_W-1:0] COEF_G_CB = 16'sd5631;
    localparam logic signed [SAMPLE_W-1:0] COEF_G_CR = 16'sd11703;
    localparam logic signed [SAMPLE_W-1:0] COEF_B_CB = 16'sd29032;
    localparam logic signed [LUM_W-1:0]    LUMA_BIAS = 17'sd128;
    localparam logic signed [SUM_W-1:0]    Q_HALF    = 34'sd8192;
    localparam logic [7:0]                 ALPHA_OPAQUE = 8'hFF;

    // Output payload width: x, y, abgr packed, rounded to bytes
    localparam int PIX_BITS = 2 * COORD_W + 32;
    localparam int OUT_TDATA_W = ((PIX_BITS + 7) / 8) * 8;

    // Chroma store request from the sequencer
    typedef struct packed {
        logic                 wr_cr;
        logic                 wr_cb;
        logic                 rd_en;
        logic [CHROMA_AW-1:0] addr;
        logic [SAMPLE_W-1:0]  wdata;
    } t_mem_req;

    // Pixel tag that travels with the data down the pipeline
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_pix_tag;

    // Round-free clamp of a Q14 sum (rounding already added) to 0..255
    function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (|sum[SUM_W-2:Q_SHIFT+8]) begin
            res = 8'hFF;
        end else begin
            res = sum[Q_SHIFT+7:Q_SHIFT];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/mbycc_chroma_mem.sv -----
// Cr and Cb stores of one macroblock, synchronous write, registered read.
module mbycc_chroma_mem
    import mbycc_pkg::*;
(
    input  logic                i_clk,
    input  t_mem_req            i_req,
    output logic [SAMPLE_W-1:0] o_cr,
    output logic [SAMPLE_W-1:0] o_cb
);

    logic [SAMPLE_W-1:0] r_cr_mem [CHROMA_DEPTH];
    logic [SAMPLE_W-1:0] r_cb_mem [CHROMA_DEPTH];
    logic [SAMPLE_W-1:0] r_cr_q;
    logic [SAMPLE_W-1:0] r_cb_q;

    // Writes: one sample per request, into the block being loaded
    always_ff @(posedge i_clk) begin
        if (i_req.wr_cr) begin
            r_cr_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.wr_cb) begin
            r_cb_mem[i_req.addr] <= i_req.wdata;
        end
    end

    // Read port: data held while the pipeline stage downstream is stalled
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_cr_q <= r_cr_mem[i_req.addr];
            r_cb_q <= r_cb_mem[i_req.addr];
        end
    end

    assign o_cr = r_cr_q;
    assign o_cb = r_cb_q;

endmodule

// ----- rtl/core/mbycc_convert.sv -----
// Color conversion pipeline: product stage, then sum/clamp output register.
module mbycc_convert
    import mbycc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // upstream
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_pix_tag                 i_tag,
    input  logic signed [LUM_W-1:0]  i_lum,
    input  logic signed [SAMPLE_W-1:0] i_cr,
    input  logic signed [SAMPLE_W-1:0] i_cb,
    // downstream
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_pix_tag                 o_tag,
    output logic [31:0]              o_abgr
);

    logic                     r2_valid;
    t_pix_tag                 r2_tag;
    logic signed [LUM_W-1:0]  r2_lum;
    logic signed [PROD_W-1:0] r2_p_rcr;
    logic signed [PROD_W-1:0] r2_p_gcb;
    logic signed [PROD_W-1:0] r2_p_gcr;
    logic signed [PROD_W-1:0] r2_p_bcb;

    logic                     r_out_valid;
    t_pix_tag                 r_out_tag;
    logic [31:0]              r_out_abgr;

    logic                     en2;
    logic                     en3;
    logic signed [SUM_W-1:0]  lum_q;
    logic signed [SUM_W-1:0]  sum_r;
    logic signed [SUM_W-1:0]  sum_g;
    logic signed [SUM_W-1:0]  sum_b;

    // Stage enables: a stage moves when it is empty or its successor moves
    assign en3        = !r_out_valid || i_out_ready;
    assign en2        = !r2_valid || en3;
    assign o_in_ready = en2;

    // Product stage: one multiplier per term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_in_valid) begin
            r2_tag   <= i_tag;
            r2_lum   <= i_lum;
            r2_p_rcr <= i_cr * COEF_R_CR;
            r2_p_gcb <= i_cb * COEF_G_CB;
            r2_p_gcr <= i_cr * COEF_G_CR;
            r2_p_bcb <= i_cb * COEF_B_CB;
        end
    end

    // Sums in Q14 with rounding half
    assign lum_q = SUM_W'({r2_lum, {Q_SHIFT{1'b0}}}) |
                   {{(SUM_W-LUM_W-Q_SHIFT){r2_lum[LUM_W-1]}}, {(LUM_W+Q_SHIFT){1'b0}}};
    assign sum_r = lum_q + SUM_W'(r2_p_rcr) + Q_HALF;
    assign sum_g = lum_q - SUM_W'(r2_p_gcb) - SUM_W'(r2_p_gcr) + Q_HALF;
    assign sum_b = lum_q + SUM_W'(r2_p_bcb) + Q_HALF;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en3) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid) begin
            r_out_tag  <= r2_tag;
            r_out_abgr <= {ALPHA_OPAQUE, clamp_byte(sum_b), clamp_byte(sum_g),
                           clamp_byte(sum_r)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tag       = r_out_tag;
    assign o_abgr      = r_out_abgr;

endmodule

// ----- rtl/core/macroblock_ycbcr_to_rgb.sv -----
// Top level: 4:2:0 macroblock YCbCr to ABGR pixel converter.
//
//  channel   dir  request contents (tdata from bit 0 up)          end marker
//  s_axis    in   sample[15:0]                                     -
//  m_axis    out  pixel_x[3:0], pixel_y[7:4], pixel_abgr[39:8]     tlast = last_pixel
//
//  One request per clock on both sides unless m_axis stalls. A macroblock is 384 input requests
//  (64 Cr, 64 Cb, 256 luma); only luma requests produce pixels.
//  A luma request's pixel passes the chroma store read (loaded at its
//  accepting edge), the product register and the sum/clamp output
//  register before it is valid.
//  Reset (i_rst_n low, synchronous) empties the pipeline and restarts the
//  sample count at the first Cr sample; the chroma stores are not cleared.
//  A stall on m_axis backs up through the stage enables; s_axis_tready
//  drops only when all three stages hold pixels.
module macroblock_ycbcr_to_rgb
    import mbycc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // sample[15:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_x[3:0], pixel_y[7:4], abgr[39:8]
    output logic                   m_axis_tlast    // last_pixel
);

    `include "assert_macros.svh"

    logic [POS_W-1:0]          r_pos;
    logic                      r1_valid;
    t_pix_tag                  r1_tag;
    logic signed [LUM_W-1:0]   r1_lum;

    logic                      en1;
    logic                      accept;
    logic                      is_luma;
    logic [7:0]                luma_idx;
    logic [COORD_W-1:0]        pix_x;
    logic [COORD_W-1:0]        pix_y;
    logic [CHROMA_AW-1:0]      chroma_idx;
    t_mem_req                  mem_req;
    t_pix_tag                  cur_tag;
    logic [SAMPLE_W-1:0]       mem_cr;
    logic [SAMPLE_W-1:0]       mem_cb;
    logic                      cv_in_ready;
    t_pix_tag                  out_tag;
    logic [31:0]               out_abgr;

    // Handshake into the read stage
    assign en1           = !r1_valid || cv_in_ready;
    assign s_axis_tready = en1;
    assign accept        = s_axis_tvalid && en1;

    // Position decode: luma block, row and column to pixel coordinates
    assign is_luma    = (r_pos >= POS_LUMA);
    assign luma_idx   = 8'(r_pos - POS_LUMA);
    assign pix_x      = {luma_idx[6], luma_idx[2:0]};
    assign pix_y      = {luma_idx[7], luma_idx[5:3]};
    assign chroma_idx = {pix_y[COORD_W-1:1], pix_x[COORD_W-1:1]};

    always_comb begin
        cur_tag.x    = pix_x;
        cur_tag.y    = pix_y;
        cur_tag.last = (r_pos == POS_LAST);
    end

    // Chroma store request: write during the chroma phase, read for luma
    always_comb begin
        mem_req.wr_cr = accept && (r_pos < POS_CB_START);
        mem_req.wr_cb = accept && (r_pos >= POS_CB_START) && !is_luma;
        mem_req.rd_en = en1;
        mem_req.addr  = is_luma ? chroma_idx : r_pos[CHROMA_AW-1:0];
        mem_req.wdata = s_axis_tdata;
    end

    // Sample position counter, wraps at the end of a macroblock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
        end
    end

    // Read stage: luma and tag wait for the chroma read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= accept && is_luma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_luma) begin
            r1_tag <= cur_tag;
            r1_lum <= LUM_W'($signed(s_axis_tdata)) + LUMA_BIAS;
        end
    end

    mbycc_chroma_mem u_chroma_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_cr  (mem_cr),
        .o_cb  (mem_cb)
    );

    mbycc_convert u_convert (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r1_valid),
        .o_in_ready  (cv_in_ready),
        .i_tag       (r1_tag),
        .i_lum       (r1_lum),
        .i_cr        ($signed(mem_cr)),
        .i_cb        ($signed(mem_cb)),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_tag       (out_tag),
        .o_abgr      (out_abgr)
    );

    // Output packing
    assign m_axis_tdata = OUT_TDATA_W'({out_abgr, out_tag.y, out_tag.x});
    assign m_axis_tlast = out_tag.last;

    // Checks
    `ASSERT_CLK(a_pos_range, r_pos <= POS_LAST, "sample position out of range")
    `ASSERT_CLK(a_last_corner,
        !(m_axis_tvalid && m_axis_tlast) || (m_axis_tdata[7:0] == 8'hFF),
        "last pixel is not the bottom-right corner")
    `ASSERT_NEXT(a_wrap_last, accept && (r_pos == POS_LAST), r_pos == '0,
        "position did not wrap after the final sample")

endmodule
